// ----- rtl/core/knn_majority_classifier_unit_assert.svh -----
// Assertion macros used by the bound checker knn_chk.
`ifndef KNN_MAJORITY_CLASSIFIER_UNIT_ASSERT_SVH
`define KNN_MAJORITY_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KNN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KNN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/knn_pkg.sv -----
`default_nettype none
package knn_pkg;

  localparam int FEAT_W      = 12;
  localparam int NUM_FEAT    = 4;
  localparam int CLASS_W     = 2;
  localparam int NUM_CLASSES = 4;
  localparam int CFG_W       = 5;
  localparam int VOTE_OUT_W  = 5;
  localparam int SQ_W        = 2 * FEAT_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int ENTRY_W     = NUM_FEAT * FEAT_W + CLASS_W;
  localparam int FIDX_W      = 3;

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(3);

  // Input word kinds.
  localparam logic KIND_STORE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_DIST = 7'b0000100,
    S_INS  = 7'b0001000,
    S_VOTE = 7'b0010000,
    S_PICK = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/knn_majority_classifier_unit.sv -----
// Store word: written to the table while idle; the input stays ready.
// Classify word: for each of the N stored samples, the single squaring unit walks the four
// features in turn; then one vote per neighbor and one class compare per cycle. The input
// stays closed until the result word is delivered.
// The next word can be taken in the cycle after the result word is delivered.
// Reset (rst_n low, synchronous) empties the table and sets k to 3.
`default_nettype none
module knn_majority_classifier_unit #(
  parameter int MAX_SAMPLES   = 128,
  parameter int MAX_NEIGHBORS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_kind,
  input  wire  [knn_pkg::FEAT_W-1:0]          in_feature_0,
  input  wire  [knn_pkg::FEAT_W-1:0]          in_feature_1,
  input  wire  [knn_pkg::FEAT_W-1:0]          in_feature_2,
  input  wire  [knn_pkg::FEAT_W-1:0]          in_feature_3,
  input  wire  [knn_pkg::CLASS_W-1:0]         in_class_in,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [knn_pkg::CLASS_W-1:0]         out_predicted_class,
  output logic [knn_pkg::VOTE_OUT_W-1:0]      out_winning_votes,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [knn_pkg::CFG_W-1:0]           cfg_neighbor_count
);
  import knn_pkg::*;

  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int NIDX = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  // Sample table: features packed low, class on top.
  logic [ENTRY_W-1:0] sample_mem [MAX_SAMPLES];
  logic [ENTRY_W-1:0] rd_r;

  state_t              state_r;
  logic [CFG_W-1:0]    kcfg_r;
  logic [CNTW-1:0]     count_r;
  logic [AW-1:0]       idx_r;
  logic [FIDX_W-1:0]   fidx_r;
  logic [FEAT_W-1:0]   query_r [NUM_FEAT];
  logic [SQ_W-1:0]     prod_r;
  logic [DIST_W-1:0]   acc_r;
  logic [KW-1:0]       k_r;
  logic [KW-1:0]       kept_r;
  logic [KW-1:0]       vidx_r;
  logic [CLASS_W-1:0]  cidx_r;
  logic [DIST_W-1:0]   best_d_r [MAX_NEIGHBORS];
  logic [CLASS_W-1:0]  best_c_r [MAX_NEIGHBORS];
  logic [KW-1:0]       votes_r  [NUM_CLASSES];
  logic [KW-1:0]       win_v_r;
  logic [CLASS_W-1:0]  win_c_r;

  logic                in_fire;
  logic [ENTRY_W-1:0]  wr_entry;
  logic [KW-1:0]       k_nxt;
  logic [31:0]         k_tmp;
  logic [FEAT_W-1:0]   qf;
  logic [FEAT_W-1:0]   sf;
  logic [FEAT_W-1:0]   diff;
  logic [MAX_NEIGHBORS-1:0] gt;
  logic [DIST_W-1:0]   ins_d_nxt [MAX_NEIGHBORS];
  logic [CLASS_W-1:0]  ins_c_nxt [MAX_NEIGHBORS];
  logic                last_sample;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_predicted_class = win_c_r;
  assign out_winning_votes   = VOTE_OUT_W'(win_v_r);

  assign wr_entry = {in_class_in, in_feature_3, in_feature_2, in_feature_1, in_feature_0};

  // Effective k: clamp to [1, MAX_NEIGHBORS], then to the table fill.
  always_comb begin
    k_tmp = 32'(kcfg_r);
    if (k_tmp == 32'd0) begin
      k_tmp = 32'd1;
    end
    if (k_tmp > 32'(MAX_NEIGHBORS)) begin
      k_tmp = 32'(MAX_NEIGHBORS);
    end
    if (k_tmp > 32'(count_r)) begin
      k_tmp = 32'(count_r);
    end
    k_nxt = KW'(k_tmp);
  end

  // Shared squaring unit: one feature difference per cycle.
  always_comb begin
    qf   = query_r[fidx_r[1:0]];
    sf   = rd_r[FEAT_W*fidx_r[1:0] +: FEAT_W];
    diff = (qf >= sf) ? (qf - sf) : (sf - qf);
  end

  // Sorted insert: entries farther than the new distance move down one
  // place; ties keep the older sample ahead.
  always_comb begin
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      gt[j] = (KW'(j) < kept_r) && (best_d_r[j] > acc_r);
    end
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      ins_d_nxt[j] = best_d_r[j];
      ins_c_nxt[j] = best_c_r[j];
      if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
        ins_d_nxt[j] = best_d_r[(j > 0) ? j - 1 : 0];
        ins_c_nxt[j] = best_c_r[(j > 0) ? j - 1 : 0];
      end else if (gt[j] || KW'(j) == kept_r) begin
        ins_d_nxt[j] = acc_r;
        ins_c_nxt[j] = rd_r[ENTRY_W-1 -: CLASS_W];
      end
    end
  end

  assign last_sample = (CNTW'(idx_r) + CNTW'(1)) == count_r;

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (in_fire && in_kind == KIND_STORE && count_r < CNTW'(MAX_SAMPLES)) begin
      sample_mem[count_r[AW-1:0]] <= wr_entry;
    end
    if (state_r == S_READ) begin
      rd_r <= sample_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kcfg_r  <= K_RESET;
      count_r <= '0;
      kept_r  <= '0;
      idx_r   <= '0;
      fidx_r  <= '0;
      vidx_r  <= '0;
      cidx_r  <= '0;
      k_r     <= '0;
      win_v_r <= '0;
      win_c_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        kcfg_r <= cfg_neighbor_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_kind == KIND_STORE) begin
              if (count_r < CNTW'(MAX_SAMPLES)) begin
                count_r <= count_r + CNTW'(1);
              end
            end else begin
              query_r[0] <= in_feature_0;
              query_r[1] <= in_feature_1;
              query_r[2] <= in_feature_2;
              query_r[3] <= in_feature_3;
              k_r     <= k_nxt;
              kept_r  <= '0;
              idx_r   <= '0;
              vidx_r  <= '0;
              for (int c = 0; c < NUM_CLASSES; c++) begin
                votes_r[c] <= '0;
              end
              state_r <= (count_r == '0) ? S_VOTE : S_READ;
            end
          end
        end
        S_READ: begin
          fidx_r  <= '0;
          acc_r   <= '0;
          prod_r  <= '0;
          state_r <= S_DIST;
        end
        S_DIST: begin
          // Square one feature, fold the previous square into the sum.
          prod_r <= SQ_W'(diff) * SQ_W'(diff);
          acc_r  <= acc_r + DIST_W'(prod_r);
          fidx_r <= fidx_r + FIDX_W'(1);
          if (fidx_r == FIDX_W'(NUM_FEAT)) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            best_d_r[j] <= ins_d_nxt[j];
            best_c_r[j] <= ins_c_nxt[j];
          end
          if (kept_r < k_r) begin
            kept_r <= kept_r + KW'(1);
          end
          if (last_sample) begin
            state_r <= S_VOTE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_READ;
          end
        end
        S_VOTE: begin
          if (vidx_r == kept_r) begin
            cidx_r  <= '0;
            win_v_r <= '0;
            win_c_r <= '0;
            state_r <= S_PICK;
          end else begin
            votes_r[best_c_r[vidx_r[NIDX-1:0]]] <=
              votes_r[best_c_r[vidx_r[NIDX-1:0]]] + KW'(1);
            vidx_r <= vidx_r + KW'(1);
          end
        end
        S_PICK: begin
          // Strictly greater: lower class wins a tie.
          if (votes_r[cidx_r] > win_v_r) begin
            win_v_r <= votes_r[cidx_r];
            win_c_r <= cidx_r;
          end
          cidx_r <= cidx_r + CLASS_W'(1);
          if (cidx_r == CLASS_W'(NUM_CLASSES - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/knn_chk.sv -----
`default_nettype none
`include "knn_majority_classifier_unit_assert.svh"
module knn_chk #(
  parameter int MAX_NEIGHBORS = 16
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                in_kind,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [knn_pkg::CLASS_W-1:0]         out_predicted_class,
  input wire [knn_pkg::VOTE_OUT_W-1:0]      out_winning_votes
);
  import knn_pkg::*;

  `KNN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `KNN_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input open while result pending")
  `KNN_ASSERT_NXT(a_query_busy, in_valid && in_ready && in_kind == KIND_CLASSIFY, !in_ready, "query not held")
  `KNN_ASSERT_IMP(a_zero_votes, out_valid && out_winning_votes == '0, out_predicted_class == '0, "empty vote not class 0")

endmodule

bind knn_majority_classifier_unit knn_chk #(
  .MAX_NEIGHBORS(MAX_NEIGHBORS)
) u_knn_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_kind            (in_kind),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_predicted_class(out_predicted_class),
  .out_winning_votes  (out_winning_votes)
);
`default_nettype wire

// ----- tb/sv/knn_majority_classifier_unit_checker.sv -----
`timescale 1ns / 1ps
module knn_majority_classifier_unit_checker #(
  parameter int MAX_SAMPLES   = 128,
  parameter int MAX_NEIGHBORS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_ready,
  input  wire                             in_kind,
  input  wire [knn_pkg::FEAT_W-1:0]       in_feature_0,
  input  wire [knn_pkg::FEAT_W-1:0]       in_feature_1,
  input  wire [knn_pkg::FEAT_W-1:0]       in_feature_2,
  input  wire [knn_pkg::FEAT_W-1:0]       in_feature_3,
  input  wire [knn_pkg::CLASS_W-1:0]      in_class_in,
  input  wire                             out_valid,
  input  wire                             out_ready,
  input  wire [knn_pkg::CLASS_W-1:0]      out_predicted_class,
  input  wire [knn_pkg::VOTE_OUT_W-1:0]   out_winning_votes,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire [knn_pkg::CFG_W-1:0]        cfg_neighbor_count,
  output int                              fail_count,
  output int                              pending,
  output int                              queries_seen,
  output int                              stores_kept,
  output int                              stores_dropped
);
  import knn_pkg::*;

  typedef struct packed {
    logic [CLASS_W-1:0]    cls;
    logic [VOTE_OUT_W-1:0] votes;
  } vote_result_t;

  logic [FEAT_W-1:0]  table_feat [MAX_SAMPLES][NUM_FEAT];
  logic [CLASS_W-1:0] table_cls  [MAX_SAMPLES];
  int                 table_fill;
  logic [CFG_W-1:0]   k_reg;
  vote_result_t       expected_votes [$];

  function automatic logic [DIST_W-1:0] sq_distance(int idx, logic [FEAT_W-1:0] q [NUM_FEAT]);
    logic [DIST_W-1:0] sum;
    logic [FEAT_W-1:0] d;
    sum = '0;
    for (int f = 0; f < NUM_FEAT; f++) begin
      d = (table_feat[idx][f] >= q[f]) ? table_feat[idx][f] - q[f] : q[f] - table_feat[idx][f];
      sum += DIST_W'(d) * DIST_W'(d);
    end
    return sum;
  endfunction

  // Pick the k closest one at a time; strict compare lets the lower index win.
  function automatic vote_result_t majority_vote(logic [FEAT_W-1:0] q [NUM_FEAT]);
    vote_result_t r;
    logic [DIST_W-1:0] sample_dist [MAX_SAMPLES];
    bit taken [MAX_SAMPLES];
    int tally [NUM_CLASSES];
    int k_eff, best;
    k_eff = (k_reg == 0) ? 1 : int'(k_reg);
    if (k_eff > MAX_NEIGHBORS) k_eff = MAX_NEIGHBORS;
    if (k_eff > table_fill) k_eff = table_fill;
    for (int i = 0; i < table_fill; i++) begin
      sample_dist[i] = sq_distance(i, q);
      taken[i] = 0;
    end
    for (int c = 0; c < NUM_CLASSES; c++) tally[c] = 0;
    for (int j = 0; j < k_eff; j++) begin
      best = -1;
      for (int i = 0; i < table_fill; i++)
        if (!taken[i] && (best < 0 || sample_dist[i] < sample_dist[best])) best = i;
      taken[best] = 1;
      tally[table_cls[best]]++;
    end
    r = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (tally[c] > int'(r.votes)) begin
        r.votes = VOTE_OUT_W'(tally[c]);
        r.cls   = CLASS_W'(c);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [FEAT_W-1:0] q [NUM_FEAT];
    vote_result_t want;
    if (!rst_n) begin
      table_fill <= 0;
      k_reg      <= K_RESET;
      expected_votes.delete();
      fail_count <= 0;
      queries_seen <= 0;
      stores_kept <= 0;
      stores_dropped <= 0;
    end else begin
      if (cfg_valid && cfg_ready) k_reg <= cfg_neighbor_count;
      // On each accepted input word, store the sample or predict the query result.
      if (in_valid && in_ready) begin
        q[0] = in_feature_0; q[1] = in_feature_1; q[2] = in_feature_2; q[3] = in_feature_3;
        if (in_kind == KIND_STORE) begin
          if (table_fill < MAX_SAMPLES) begin
            for (int f = 0; f < NUM_FEAT; f++) table_feat[table_fill][f] = q[f];
            table_cls[table_fill] = in_class_in;
            table_fill <= table_fill + 1;
            stores_kept <= stores_kept + 1;
          end else begin
            stores_dropped <= stores_dropped + 1;
          end
        end else begin
          expected_votes.insert(expected_votes.size(), majority_vote(q));
          queries_seen <= queries_seen + 1;
        end
      end
      // Compare each delivered result word against the oldest expectation.
      if (out_valid && out_ready) begin
        if (expected_votes.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result class=%0d votes=%0d",
                     out_predicted_class, out_winning_votes);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_votes.pop_front();
          if (want.cls !== out_predicted_class || want.votes !== out_winning_votes) begin
            if (fail_count < 10)
              $display("ERROR: expected class=%0d votes=%0d, got class=%0d votes=%0d",
                       want.cls, want.votes, out_predicted_class, out_winning_votes);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_votes.size();

endmodule

// ----- tb/sv/knn_majority_classifier_unit_tb.sv -----
`timescale 1ns / 1ps
module knn_majority_classifier_unit_tb;
  import knn_pkg::*;

  localparam int   FEAT_MAX      = (1 << FEAT_W) - 1;
  localparam int   STALL_LIMIT   = 20000;
  localparam int   PHASES        = 8;
  localparam int   WORDS_PER_PHASE = 54;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_kind = 1'b0;
  logic [FEAT_W-1:0] in_feature_0 = '0, in_feature_1 = '0, in_feature_2 = '0, in_feature_3 = '0;
  logic [CLASS_W-1:0] in_class_in = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_neighbor_count = '0;
  wire in_ready, out_valid, cfg_ready;
  wire [CLASS_W-1:0] out_predicted_class;
  wire [VOTE_OUT_W-1:0] out_winning_votes;

  int fail_count, pending, queries_seen, stores_kept, stores_dropped;
  int send_idle_pct, recv_idle_pct;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // k sweep after the directed part at the reset value: extremes, out-of-range and mid values.
  int k_sweep [PHASES] = '{1, 16, 0, 31, 17, 5, 8, 2};

  always #5 clk = ~clk;

  knn_majority_classifier_unit u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_feature_0, .in_feature_1,
    .in_feature_2, .in_feature_3, .in_class_in, .out_valid, .out_ready,
    .out_predicted_class, .out_winning_votes, .cfg_valid, .cfg_ready, .cfg_neighbor_count
  );

  knn_majority_classifier_unit_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_feature_0, .in_feature_1,
    .in_feature_2, .in_feature_3, .in_class_in, .out_valid, .out_ready,
    .out_predicted_class, .out_winning_votes, .cfg_valid, .cfg_ready, .cfg_neighbor_count,
    .fail_count, .pending, .queries_seen, .stores_kept, .stores_dropped
  );

  // Result side: random back-pressure, or a long counted hold when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 3000;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("knn_majority_classifier_unit test failed");
      $finish;
    end
  end

  // Offer one word; hold it until the handshake completes.
  task automatic send_word(logic kind, int f0, int f1, int f2, int f3, int cls);
    logic rdy;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_feature_0 <= FEAT_W'(f0);
    in_feature_1 <= FEAT_W'(f1);
    in_feature_2 <= FEAT_W'(f2);
    in_feature_3 <= FEAT_W'(f3);
    in_class_in  <= CLASS_W'(cls);
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Drain all results, let the block settle, then write k.
  task automatic write_k(int k);
    logic rdy;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_neighbor_count <= CFG_W'(k);
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
  endtask

  // Clustered value around a per-class center, clamped to the field range.
  function automatic int near_center(int cls, int f);
    int v;
    v = 400 + cls * 1000 + f * 60 + $urandom_range(0, 500) - 250;
    return (v < 0) ? 0 : (v > FEAT_MAX ? FEAT_MAX : v);
  endfunction

  task automatic random_word();
    int cls, f [4];
    logic kind;
    kind = ($urandom_range(0, 99) < 45) ? KIND_STORE : KIND_CLASSIFY;
    cls  = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 9))
        0:       f[i] = 0;
        1:       f[i] = FEAT_MAX;
        2, 3:    f[i] = $urandom_range(0, FEAT_MAX);
        default: f[i] = near_center(cls, i);
      endcase
    end
    // Occasionally mislabel a sample so neighborhoods mix.
    if ($urandom_range(0, 9) == 0) cls = $urandom_range(0, 3);
    send_word(kind, f[0], f[1], f[2], f[3], cls);
  endtask

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 68;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, distance ties and vote ties at k = 3.
    send_word(KIND_CLASSIFY, 100, 200, 300, 400, 2);
    send_word(KIND_STORE, 0, 0, 0, 0, 0);
    send_word(KIND_CLASSIFY, FEAT_MAX, FEAT_MAX, FEAT_MAX, FEAT_MAX, 0);
    send_word(KIND_STORE, FEAT_MAX, FEAT_MAX, FEAT_MAX, FEAT_MAX, 3);
    send_word(KIND_STORE, 'hAAA, 'h555, 'hAAA, 'h555, 1);
    send_word(KIND_STORE, 'h555, 'hAAA, 'h555, 'hAAA, 2);
    send_word(KIND_STORE, 0, 0, 0, 0, 1);
    send_word(KIND_CLASSIFY, 0, 0, 0, 0, 3);
    send_word(KIND_CLASSIFY, FEAT_MAX, FEAT_MAX, FEAT_MAX, FEAT_MAX, 1);
    send_word(KIND_CLASSIFY, 2048, 2048, 2048, 2048, 0);
    send_word(KIND_CLASSIFY, 0, FEAT_MAX, 0, FEAT_MAX, 0);
    send_word(KIND_STORE, 10, 10, 10, 10, 2);
    send_word(KIND_STORE, 10, 10, 10, 10, 3);
    send_word(KIND_CLASSIFY, 5, 5, 5, 5, 0);
    send_word(KIND_CLASSIFY, 'hAAA, 'h555, 'hAAA, 'h555, 2);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 17;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_k(k_sweep[p]);
      if (p == 1) hold_requests <= hold_requests + 1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) random_word();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Coverage: %0d classify queries, %0d samples stored, %0d stores past a full table",
             queries_seen, stores_kept, stores_dropped);
    $display("k swept through reset, 1, 16, 0, 31, 17, 5, 8 and 2 under three idle profiles");
    if (fail_count == 0) begin
      $display("knn_majority_classifier_unit test passed");
    end else begin
      $display("knn_majority_classifier_unit test failed");
    end
    $finish;
  end

endmodule
